// File: src/assert_macros.svh
// Assertion macros used by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: src/plte_pkg.sv
// ----------------------------------------------------------------------------
// plte_pkg
// Types and constants of the packed list table engine.
// ----------------------------------------------------------------------------
package plte_pkg;
  localparam int LIST_CAPACITY = 128;
  localparam int VAL_W = 31;

  typedef enum logic [3:0] {
    ACT_CLEAR     = 4'd0,
    ACT_INS_FIRST = 4'd1,
    ACT_INS_AT    = 4'd2,
    ACT_INS_LAST  = 4'd3,
    ACT_DEL_FIRST = 4'd4,
    ACT_DEL_AT    = 4'd5,
    ACT_DEL_LAST  = 4'd6,
    ACT_SEARCH    = 4'd7,
    ACT_EXTREMES  = 4'd8,
    ACT_SORT      = 4'd9,
    ACT_READ      = 4'd10
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHR_RD,   // insert: read entry i-1
    S_SHR_WR,   // insert: write entry i
    S_SHL_RD,   // delete: read entry i+1
    S_SHL_WR,   // delete: write entry i
    S_SCAN_RD,  // search / extremes / read / delete: issue read
    S_SCAN_CK,  // compare returned data
    S_SRT_RDI,  // sort: read entry i
    S_SRT_RDJ,  // sort: read entry j
    S_SRT_CK,   // compare, maybe write j
    S_SRT_WRI,  // write i after a swap
    S_DONE
  } state_t;
endpackage

// File: src/packed_list_table_engine.sv
// ----------------------------------------------------------------------------
// packed_list_table_engine
// Left-packed list in a single-port RAM, driven by a small sequencer.
// ----------------------------------------------------------------------------
// channel  | ports                                          | handshake
// command  | action value position ascending                | start & !busy
// result   | status element_value found_index max/min length| done, 1 cycle
//
// One RAM port is shared by all actions; every step is one RAM access.
// Clear, rejects and no-op actions go straight to done. Insert moves
// entries right down to p by read/write pairs, then writes the value;
// delete reads the element and moves the tail left likewise; search and
// extremes read and compare entry by entry; sort swaps out-of-order i, j.
// Reset clears the count and sequencer only; RAM contents stay undefined.
// The receiver cannot stall; busy stays high until done has been shown.
module packed_list_table_engine #(
  parameter int LIST_CAPACITY = plte_pkg::LIST_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  action,
  input  logic [30:0] value,
  input  logic [7:0]  position,
  input  logic        ascending,
  output logic        done,
  output logic [2:0]  status,
  output logic [30:0] element_value,
  output logic [6:0]  found_index,
  output logic [30:0] max_value,
  output logic [30:0] min_value,
  output logic [7:0]  length
);
`include "assert_macros.svh"
  localparam int AW = $clog2(LIST_CAPACITY);
  localparam int CW = $clog2(LIST_CAPACITY + 1);
  localparam int PW = (CW > 8) ? CW : 8;
  localparam int VW = plte_pkg::VAL_W;

  plte_pkg::state_t state, state_next;
  logic [3:0]  act;
  logic [VW-1:0] val;
  logic        asc;
  logic [CW-1:0] cnt, i, j, tgt;
  logic [VW-1:0] vi, mx, mn, elem;
  logic [2:0]  st;
  logic [CW-1:0] fidx;

  logic          we;
  logic [AW-1:0] addr;
  logic [VW-1:0] wdata, rdata;

  plte_ram #(.WIDTH(VW), .DEPTH(LIST_CAPACITY)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic accept;
  logic [PW-1:0] pos_ext, cnt_ext;
  logic swap;
  assign accept  = start && !busy;
  assign busy    = (state != plte_pkg::S_IDLE);
  assign pos_ext = PW'(position);
  assign cnt_ext = PW'(cnt);
  assign swap    = asc ? (vi > rdata) : (vi < rdata);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      plte_pkg::S_IDLE: begin
        if (accept) begin
          state_next = plte_pkg::S_DONE;
          case (plte_pkg::action_t'(action))
            plte_pkg::ACT_INS_FIRST, plte_pkg::ACT_INS_AT, plte_pkg::ACT_INS_LAST:
              if (cnt < CW'(LIST_CAPACITY)) begin
                if (action != plte_pkg::ACT_INS_AT || pos_ext <= cnt_ext) begin
                  state_next = plte_pkg::S_SHR_RD;
                end
              end
            plte_pkg::ACT_DEL_FIRST, plte_pkg::ACT_DEL_AT, plte_pkg::ACT_DEL_LAST:
              if (cnt != '0) begin
                if (action != plte_pkg::ACT_DEL_AT || pos_ext < cnt_ext) begin
                  state_next = plte_pkg::S_SCAN_RD;
                end
              end
            plte_pkg::ACT_SEARCH, plte_pkg::ACT_EXTREMES:
              if (cnt != '0) state_next = plte_pkg::S_SCAN_RD;
            plte_pkg::ACT_READ:
              if (pos_ext < cnt_ext) state_next = plte_pkg::S_SCAN_RD;
            plte_pkg::ACT_SORT:
              if (cnt > CW'(1)) state_next = plte_pkg::S_SRT_RDI;
            default: state_next = plte_pkg::S_DONE;
          endcase
        end
      end
      plte_pkg::S_SHR_RD: state_next = plte_pkg::S_SHR_WR;
      plte_pkg::S_SHR_WR:
        if (i == tgt) state_next = plte_pkg::S_DONE;
        else state_next = plte_pkg::S_SHR_RD;
      plte_pkg::S_SCAN_RD: state_next = plte_pkg::S_SCAN_CK;
      plte_pkg::S_SCAN_CK: begin
        case (plte_pkg::action_t'(act))
          plte_pkg::ACT_SEARCH:
            if (rdata == val || i + CW'(1) >= cnt) state_next = plte_pkg::S_DONE;
            else state_next = plte_pkg::S_SCAN_RD;
          plte_pkg::ACT_EXTREMES:
            if (i + CW'(1) >= cnt) state_next = plte_pkg::S_DONE;
            else state_next = plte_pkg::S_SCAN_RD;
          plte_pkg::ACT_READ: state_next = plte_pkg::S_DONE;
          default:
            // delete: element captured, shift the tail left
            if (i + CW'(1) >= cnt) state_next = plte_pkg::S_DONE;
            else state_next = plte_pkg::S_SHL_RD;
        endcase
      end
      plte_pkg::S_SHL_RD: state_next = plte_pkg::S_SHL_WR;
      plte_pkg::S_SHL_WR:
        if (i + CW'(2) >= cnt) state_next = plte_pkg::S_DONE;
        else state_next = plte_pkg::S_SHL_RD;
      plte_pkg::S_SRT_RDI: state_next = plte_pkg::S_SRT_RDJ;
      plte_pkg::S_SRT_RDJ: state_next = plte_pkg::S_SRT_CK;
      plte_pkg::S_SRT_CK:
        if (swap) state_next = plte_pkg::S_SRT_WRI;
        else if (j + CW'(1) < cnt) state_next = plte_pkg::S_SRT_RDJ;
        else if (i + CW'(2) < cnt) state_next = plte_pkg::S_SRT_RDI;
        else state_next = plte_pkg::S_DONE;
      plte_pkg::S_SRT_WRI:
        if (j + CW'(1) < cnt) state_next = plte_pkg::S_SRT_RDJ;
        else if (i + CW'(2) < cnt) state_next = plte_pkg::S_SRT_RDI;
        else state_next = plte_pkg::S_DONE;
      plte_pkg::S_DONE: state_next = plte_pkg::S_IDLE;
      default: state_next = plte_pkg::S_IDLE;
    endcase
  end

  // RAM port
  always_comb begin
    we    = 1'b0;
    addr  = i[AW-1:0];
    wdata = val;
    case (state)
      plte_pkg::S_SHR_RD: addr = AW'(i - CW'(1));
      plte_pkg::S_SHR_WR: begin
        we    = 1'b1;
        wdata = (i == tgt) ? val : rdata;
      end
      plte_pkg::S_SHL_RD: addr = AW'(i + CW'(1));
      plte_pkg::S_SHL_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      plte_pkg::S_SRT_RDJ: addr = j[AW-1:0];
      plte_pkg::S_SRT_CK: begin
        addr  = j[AW-1:0];
        we    = swap;
        wdata = vi;
      end
      plte_pkg::S_SRT_WRI: begin
        we    = 1'b1;
        wdata = vi;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plte_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        plte_pkg::S_IDLE:
          if (accept) begin
            act  <= action;
            val  <= value;
            asc  <= ascending;
            st   <= plte_pkg::ST_OK;
            elem <= '0;
            fidx <= '0;
            mx   <= '0;
            mn   <= '0;
            i    <= '0;
            case (plte_pkg::action_t'(action))
              plte_pkg::ACT_CLEAR: cnt <= '0;
              plte_pkg::ACT_INS_FIRST, plte_pkg::ACT_INS_AT, plte_pkg::ACT_INS_LAST: begin
                i <= cnt;
                tgt <= (action == plte_pkg::ACT_INS_FIRST) ? '0 :
                       (action == plte_pkg::ACT_INS_LAST) ? cnt : CW'(pos_ext);
                if (cnt >= CW'(LIST_CAPACITY)) st <= plte_pkg::ST_FULL;
                else if (action == plte_pkg::ACT_INS_AT && pos_ext > cnt_ext)
                  st <= plte_pkg::ST_BADIDX;
              end
              plte_pkg::ACT_DEL_FIRST, plte_pkg::ACT_DEL_AT, plte_pkg::ACT_DEL_LAST: begin
                i <= (action == plte_pkg::ACT_DEL_FIRST) ? '0 :
                     (action == plte_pkg::ACT_DEL_LAST) ? cnt - CW'(1) : CW'(pos_ext);
                if (cnt == '0) st <= plte_pkg::ST_EMPTY;
                else if (action == plte_pkg::ACT_DEL_AT && pos_ext >= cnt_ext)
                  st <= plte_pkg::ST_BADIDX;
              end
              plte_pkg::ACT_SEARCH: if (cnt == '0) st <= plte_pkg::ST_NOTFOUND;
              plte_pkg::ACT_EXTREMES: if (cnt == '0) st <= plte_pkg::ST_EMPTY;
              plte_pkg::ACT_READ: begin
                i <= CW'(pos_ext);
                if (pos_ext >= cnt_ext) st <= plte_pkg::ST_BADIDX;
              end
              default: ;
            endcase
          end
        plte_pkg::S_SHR_WR:
          if (i == tgt) cnt <= cnt + CW'(1);
          else i <= i - CW'(1);
        plte_pkg::S_SCAN_CK: begin
          case (plte_pkg::action_t'(act))
            plte_pkg::ACT_SEARCH:
              if (rdata == val) fidx <= i;
              else if (i + CW'(1) >= cnt) st <= plte_pkg::ST_NOTFOUND;
            plte_pkg::ACT_EXTREMES: begin
              if (i == '0 || rdata > mx) mx <= rdata;
              if (i == '0 || rdata < mn) mn <= rdata;
            end
            plte_pkg::ACT_READ: elem <= rdata;
            default: begin
              elem <= rdata;
              if (i + CW'(1) >= cnt) cnt <= cnt - CW'(1);
            end
          endcase
          if (act != plte_pkg::ACT_READ && act != plte_pkg::ACT_DEL_FIRST &&
              act != plte_pkg::ACT_DEL_AT && act != plte_pkg::ACT_DEL_LAST)
            i <= i + CW'(1);
        end
        plte_pkg::S_SHL_WR: begin
          i <= i + CW'(1);
          if (i + CW'(2) >= cnt) cnt <= cnt - CW'(1);
        end
        plte_pkg::S_SRT_RDI: j <= i + CW'(1);
        plte_pkg::S_SRT_RDJ: if (j == i + CW'(1)) vi <= rdata;
        plte_pkg::S_SRT_CK: begin
          if (swap) vi <= rdata;
          if (!swap) begin
            if (j + CW'(1) < cnt) j <= j + CW'(1);
            else i <= i + CW'(1);
          end
        end
        plte_pkg::S_SRT_WRI:
          if (j + CW'(1) < cnt) j <= j + CW'(1);
          else i <= i + CW'(1);
        default: ;
      endcase
    end
  end

  assign done          = (state == plte_pkg::S_DONE);
  assign status        = st;
  assign element_value = elem;
  assign found_index   = 7'(fidx);
  assign max_value     = mx;
  assign min_value     = mn;
  assign length        = 8'(cnt);

  `ASSERT_IMPL(a_cnt_range, clk, rst, cnt <= CW'(LIST_CAPACITY), "count above capacity")
  `ASSERT_NEXT(a_done_idle, clk, rst, done, !busy, "done not followed by idle")
  `ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted item left block idle")
  `ASSERT_IMPL(a_we_busy, clk, rst, !we || busy, "RAM write while idle")
endmodule

// File: src/plte_ram.sv
// ----------------------------------------------------------------------------
// plte_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module plte_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: tb/packed_list_table_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packed_list_table_engine_tb
// Drives list commands through the start/busy handshake, predicts each
// result with a software copy of the list and checks every done strobe.
// ----------------------------------------------------------------------------
module packed_list_table_engine_tb;
  localparam int CAP = plte_pkg::LIST_CAPACITY;
  localparam int RANDOM_ITEMS = 1260;
  localparam int IDLE_LIMIT = 200000;

  typedef struct {
    logic [2:0]  status;
    logic [30:0] element_value;
    logic [6:0]  found_index;
    logic [30:0] max_value;
    logic [30:0] min_value;
    logic [7:0]  length;
  } list_result_t;

  typedef struct {
    logic [3:0]  act;
    logic [30:0] val;
    logic [7:0]  pos;
    logic        asc;
    bit          typed;
    logic [2:0]  t_status;
    logic [7:0]  t_length;
  } cmd_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  action = '0;
  logic [30:0] value = '0;
  logic [7:0]  position = '0;
  logic        ascending = 1'b0;
  logic        done;
  logic [2:0]  status;
  logic [30:0] element_value;
  logic [6:0]  found_index;
  logic [30:0] max_value;
  logic [30:0] min_value;
  logic [7:0]  length;

  // typed expectation for the item being offered
  bit          typed_on = 1'b0;
  logic [2:0]  typed_status = '0;
  logic [7:0]  typed_length = '0;

  logic [30:0] shadow_list [CAP];
  int          shadow_count = 0;
  list_result_t pending_results [$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  packed_list_table_engine uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .value(value), .position(position), .ascending(ascending),
    .done(done), .status(status), .element_value(element_value),
    .found_index(found_index), .max_value(max_value), .min_value(min_value),
    .length(length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic list_result_t apply_list_cmd(logic [3:0] act, logic [30:0] val,
                                                  logic [7:0] pos, logic asc);
    list_result_t r;
    logic [30:0] t;
    int p;
    r = '{default: '0};
    r.status = plte_pkg::ST_OK;
    case (act)
      plte_pkg::ACT_CLEAR: shadow_count = 0;
      plte_pkg::ACT_INS_FIRST, plte_pkg::ACT_INS_AT, plte_pkg::ACT_INS_LAST: begin
        p = (act == plte_pkg::ACT_INS_FIRST) ? 0 :
            (act == plte_pkg::ACT_INS_LAST) ? shadow_count : int'(pos);
        if (shadow_count >= CAP) r.status = plte_pkg::ST_FULL;
        else if (p > shadow_count) r.status = plte_pkg::ST_BADIDX;
        else begin
          for (int i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = val;
          shadow_count++;
        end
      end
      plte_pkg::ACT_DEL_FIRST, plte_pkg::ACT_DEL_AT, plte_pkg::ACT_DEL_LAST: begin
        p = (act == plte_pkg::ACT_DEL_FIRST) ? 0 :
            (act == plte_pkg::ACT_DEL_LAST) ? shadow_count - 1 : int'(pos);
        if (shadow_count == 0) r.status = plte_pkg::ST_EMPTY;
        else if (p >= shadow_count) r.status = plte_pkg::ST_BADIDX;
        else begin
          r.element_value = shadow_list[p];
          for (int i = p; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
        end
      end
      plte_pkg::ACT_SEARCH: begin
        r.status = plte_pkg::ST_NOTFOUND;
        for (int i = 0; i < shadow_count; i++)
          if (shadow_list[i] == val) begin
            r.status = plte_pkg::ST_OK;
            r.found_index = i[6:0];
            break;
          end
      end
      plte_pkg::ACT_EXTREMES: begin
        if (shadow_count == 0) r.status = plte_pkg::ST_EMPTY;
        else begin
          r.max_value = shadow_list[0];
          r.min_value = shadow_list[0];
          for (int i = 1; i < shadow_count; i++) begin
            if (shadow_list[i] > r.max_value) r.max_value = shadow_list[i];
            if (shadow_list[i] < r.min_value) r.min_value = shadow_list[i];
          end
        end
      end
      plte_pkg::ACT_SORT: begin
        for (int i = 0; i + 1 < shadow_count; i++)
          for (int j = i + 1; j < shadow_count; j++)
            if (asc ? (shadow_list[i] > shadow_list[j]) : (shadow_list[i] < shadow_list[j])) begin
              t = shadow_list[i];
              shadow_list[i] = shadow_list[j];
              shadow_list[j] = t;
            end
      end
      plte_pkg::ACT_READ: begin
        if (pos >= shadow_count) r.status = plte_pkg::ST_BADIDX;
        else r.element_value = shadow_list[pos];
      end
      default: ;
    endcase
    r.length = shadow_count[7:0];
    return r;
  endfunction

  // check results first, then record the item accepted at this edge
  always @(posedge clk) begin
    list_result_t e;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding");
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status); errors++;
          end
          if (element_value !== e.element_value) begin
            $error("element_value: expected %0d, got %0d", e.element_value, element_value);
            errors++;
          end
          if (found_index !== e.found_index) begin
            $error("found_index: expected %0d, got %0d", e.found_index, found_index); errors++;
          end
          if (max_value !== e.max_value) begin
            $error("max_value: expected %0d, got %0d", e.max_value, max_value); errors++;
          end
          if (min_value !== e.min_value) begin
            $error("min_value: expected %0d, got %0d", e.min_value, min_value); errors++;
          end
          if (length !== e.length) begin
            $error("length: expected %0d, got %0d", e.length, length); errors++;
          end
        end
      end
      if (start && !busy) begin
        e = apply_list_cmd(action, value, position, ascending);
        if (typed_on) begin
          e.status = typed_status;
          e.length = typed_length;
        end
        pending_results.push_back(e);
      end
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_cmd(logic [3:0] act, logic [30:0] val, logic [7:0] pos, logic asc,
                          bit typed = 0, logic [2:0] ts = '0, logic [7:0] tl = '0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    action = act;
    value = val;
    position = pos;
    ascending = asc;
    typed_on = typed;
    typed_status = ts;
    typed_length = tl;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [30:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 31'h7FFF_FFFF;
      1: return '0;
      2: return 31'($urandom_range(0, 7));
      3: return (shadow_count > 0) ? shadow_list[$urandom_range(0, shadow_count - 1)] : '0;
      default: return 31'($urandom());
    endcase
  endfunction

  task automatic random_cmd(int grow);
    logic [3:0] act;
    logic [7:0] pos;
    int w;
    w = $urandom_range(0, 99);
    if (w < grow)
      act = 4'($urandom_range(plte_pkg::ACT_INS_FIRST, plte_pkg::ACT_INS_LAST));
    else if (w < 70)
      act = 4'($urandom_range(plte_pkg::ACT_DEL_FIRST, plte_pkg::ACT_DEL_LAST));
    else if (w < 78) act = plte_pkg::ACT_SEARCH;
    else if (w < 84) act = plte_pkg::ACT_EXTREMES;
    else if (w < 94) act = plte_pkg::ACT_READ;
    else if (w < 97)
      act = (shadow_count <= 20 || $urandom_range(0, 9) == 0) ? plte_pkg::ACT_SORT
                                                              : plte_pkg::ACT_READ;
    else if (w < 98) act = plte_pkg::ACT_CLEAR;
    else act = 4'($urandom_range(11, 15));
    if ($urandom_range(0, 7) == 0) pos = 8'($urandom_range(0, 255));
    else pos = 8'($urandom_range(0, shadow_count));
    send_cmd(act, pick_value(), pos, 1'($urandom_range(0, 1)));
  endtask

  cmd_row_t directed_rows [] = '{
    '{plte_pkg::ACT_CLEAR,     31'd0,         8'd0,   1'b0, 1, plte_pkg::ST_OK,       8'd0},
    '{plte_pkg::ACT_DEL_FIRST, 31'd0,         8'd0,   1'b0, 1, plte_pkg::ST_EMPTY,    8'd0},
    '{plte_pkg::ACT_DEL_LAST,  31'd0,         8'd0,   1'b0, 1, plte_pkg::ST_EMPTY,    8'd0},
    '{plte_pkg::ACT_DEL_AT,    31'd0,         8'd0,   1'b0, 1, plte_pkg::ST_EMPTY,    8'd0},
    '{plte_pkg::ACT_EXTREMES,  31'd0,         8'd0,   1'b0, 1, plte_pkg::ST_EMPTY,    8'd0},
    '{plte_pkg::ACT_SEARCH,    31'd0,         8'd0,   1'b0, 1, plte_pkg::ST_NOTFOUND, 8'd0},
    '{plte_pkg::ACT_READ,      31'd0,         8'd0,   1'b0, 1, plte_pkg::ST_BADIDX,   8'd0},
    '{plte_pkg::ACT_SORT,      31'd0,         8'd0,   1'b1, 1, plte_pkg::ST_OK,       8'd0},
    '{plte_pkg::ACT_INS_AT,    31'd9,         8'd1,   1'b0, 1, plte_pkg::ST_BADIDX,   8'd0},
    '{plte_pkg::ACT_INS_FIRST, 31'h7FFF_FFFF, 8'd0,   1'b0, 1, plte_pkg::ST_OK,       8'd1},
    '{plte_pkg::ACT_SORT,      31'd0,         8'd0,   1'b0, 1, plte_pkg::ST_OK,       8'd1},
    '{plte_pkg::ACT_INS_LAST,  31'd0,         8'd0,   1'b0, 1, plte_pkg::ST_OK,       8'd2},
    '{plte_pkg::ACT_INS_AT,    31'd5,         8'd1,   1'b0, 1, plte_pkg::ST_OK,       8'd3},
    '{plte_pkg::ACT_INS_AT,    31'd5,         8'd255, 1'b0, 1, plte_pkg::ST_BADIDX,   8'd3},
    '{plte_pkg::ACT_READ,      31'd0,         8'd2,   1'b0, 0, plte_pkg::ST_OK,       8'd0},
    '{plte_pkg::ACT_READ,      31'd0,         8'd128, 1'b0, 1, plte_pkg::ST_BADIDX,   8'd3},
    '{plte_pkg::ACT_EXTREMES,  31'd0,         8'd0,   1'b0, 0, plte_pkg::ST_OK,       8'd0},
    '{plte_pkg::ACT_SEARCH,    31'd5,         8'd0,   1'b0, 0, plte_pkg::ST_OK,       8'd0},
    '{plte_pkg::ACT_SORT,      31'd0,         8'd0,   1'b1, 0, plte_pkg::ST_OK,       8'd0},
    '{plte_pkg::ACT_SORT,      31'd0,         8'd0,   1'b0, 0, plte_pkg::ST_OK,       8'd0},
    '{4'd15,                   31'd0,         8'd0,   1'b0, 1, plte_pkg::ST_OK,       8'd3},
    '{plte_pkg::ACT_DEL_AT,    31'd0,         8'd3,   1'b0, 1, plte_pkg::ST_BADIDX,   8'd3},
    '{plte_pkg::ACT_DEL_AT,    31'd0,         8'd1,   1'b0, 0, plte_pkg::ST_OK,       8'd0},
    '{plte_pkg::ACT_DEL_FIRST, 31'd0,         8'd0,   1'b0, 0, plte_pkg::ST_OK,       8'd0},
    '{plte_pkg::ACT_DEL_LAST,  31'd0,         8'd0,   1'b0, 0, plte_pkg::ST_OK,       8'd0}
  };

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[k])
      send_cmd(directed_rows[k].act, directed_rows[k].val, directed_rows[k].pos,
               directed_rows[k].asc, directed_rows[k].typed, directed_rows[k].t_status,
               directed_rows[k].t_length);

    // fill to capacity, hit the full case, sort the full list twice, then drain
    while (shadow_count < CAP)
      send_cmd(plte_pkg::ACT_INS_LAST, pick_value(), '0, 1'b0);
    send_cmd(plte_pkg::ACT_INS_FIRST, 31'd1, '0, 1'b0, 1, plte_pkg::ST_FULL, 8'(CAP));
    send_cmd(plte_pkg::ACT_INS_AT, 31'd1, 8'(CAP), 1'b0, 1, plte_pkg::ST_FULL, 8'(CAP));
    send_cmd(plte_pkg::ACT_INS_LAST, 31'd1, '0, 1'b0, 1, plte_pkg::ST_FULL, 8'(CAP));
    send_cmd(plte_pkg::ACT_EXTREMES, '0, '0, 1'b0);
    send_cmd(plte_pkg::ACT_SORT, '0, '0, 1'b1);
    send_cmd(plte_pkg::ACT_READ, '0, 8'(CAP - 1), 1'b0);
    send_cmd(plte_pkg::ACT_DEL_AT, '0, 8'(CAP - 1), 1'b0);
    send_cmd(plte_pkg::ACT_INS_AT, 31'h7FFF_FFFF, 8'(CAP - 1), 1'b0);
    send_cmd(plte_pkg::ACT_SORT, '0, '0, 1'b0);
    while (shadow_count > 0)
      send_cmd(4'($urandom_range(plte_pkg::ACT_DEL_FIRST, plte_pkg::ACT_DEL_LAST)), '0,
               8'($urandom_range(0, shadow_count - 1)), 1'b0);

    // alternate growing and shrinking phases
    for (int n = 0; n < RANDOM_ITEMS; n++)
      random_cmd(((n / 200) % 2 == 0) ? 55 : 25);

    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// File: packed_list_table_engine.f
+incdir+src
src/plte_pkg.sv
src/plte_ram.sv
src/packed_list_table_engine.sv
tb/packed_list_table_engine_tb.sv
